/* rtl/core/bpc_pkg.sv */
// ----------------------------------------------------------------------------
// bpc_pkg
// Types, constants and arithmetic helpers for the barometric compensation core.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int DIV_STEPS = 32;
  localparam int ADDR_W    = 5;

  // register index codes (paddr[4:2])
  localparam logic [2:0] REG_CAL01 = 3'd0;
  localparam logic [2:0] REG_CAL23 = 3'd1;
  localparam logic [2:0] REG_CAL45 = 3'd2;
  localparam logic [2:0] REG_CAL67 = 3'd3;
  localparam logic [2:0] REG_CAL910 = 3'd4;
  localparam logic [2:0] REG_OSS   = 3'd5;

  localparam logic [1:0]  OSS_RESET   = 2'd3;
  localparam logic [31:0] B6_OFFSET   = 32'd4000;
  localparam logic [31:0] B4_BIAS     = 32'd32768;
  localparam logic [31:0] B7_SCALE    = 32'd50000;
  localparam logic [31:0] P_C1        = 32'd3038;
  localparam logic [31:0] P_C2        = 32'hFFFF_E343; // -7357
  localparam logic [31:0] P_C3        = 32'd3791;
  localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;
  localparam logic [31:0] PRES_MAX    = 32'd1048575;

  // one in-flight sample; fields are reused from stage to stage
  typedef struct packed {
    logic [31:0] up;
    logic [31:0] x1;
    logic [31:0] b5;
    logic [31:0] tv;
    logic [31:0] b4;
    logic [31:0] p;
    logic [31:0] m0;
    logic [31:0] m1;
    logic [31:0] m2;
    logic [31:0] m3;
    logic        neg;
    logic        post;
    logic        fault;
  } bpc_item_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] v, input int s);
    return 32'($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] mulw(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] pr;
    pr = a * b;
    return pr[31:0];
  endfunction

endpackage

/* rtl/core/bpc_if.sv */
// ----------------------------------------------------------------------------
// bpc_if
// Valid/ready channels for raw samples and compensated results.
// ----------------------------------------------------------------------------
interface bpc_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_temperature;
  logic [23:0] pressure_bytes;
  modport source (output valid, raw_temperature, pressure_bytes, input ready);
  modport sink (input valid, raw_temperature, pressure_bytes, output ready);
endinterface

interface bpc_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature;
  logic [19:0]        pressure;
  logic               div_fault;
  modport source (output valid, temperature, pressure, div_fault, input ready);
  modport sink (input valid, temperature, pressure, div_fault, output ready);
endinterface

/* rtl/core/bpc_udiv.sv */
// ----------------------------------------------------------------------------
// bpc_udiv
// Pipelined 32/32 unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bpc_udiv import bpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] num,
  input  logic [31:0] den,
  input  bpc_item_t   side_in,
  output logic        out_valid,
  output logic [31:0] quo,
  output bpc_item_t   side_out
);

  logic [31:0] rem_q [DIV_STEPS];
  logic [31:0] num_q [DIV_STEPS];
  logic [31:0] den_q [DIV_STEPS];
  logic [31:0] quo_q [DIV_STEPS];
  bpc_item_t   side_q [DIV_STEPS];
  logic [DIV_STEPS-1:0] vld;

  // stage inputs: stage 0 from the ports, stage k from stage k-1
  logic [31:0] rem_i [DIV_STEPS];
  logic [31:0] num_i [DIV_STEPS];
  logic [31:0] den_i [DIV_STEPS];
  logic [31:0] quo_i [DIV_STEPS];
  bpc_item_t   side_i [DIV_STEPS];

  logic [31:0] rem_n [DIV_STEPS];
  logic [31:0] num_n [DIV_STEPS];
  logic [31:0] quo_n [DIV_STEPS];

  always_comb begin
    logic [32:0] sh;
    logic        ge;
    rem_i[0]  = '0;
    num_i[0]  = num;
    den_i[0]  = den;
    quo_i[0]  = '0;
    side_i[0] = side_in;
    for (int k = 1; k < DIV_STEPS; k++) begin
      rem_i[k]  = rem_q[k-1];
      num_i[k]  = num_q[k-1];
      den_i[k]  = den_q[k-1];
      quo_i[k]  = quo_q[k-1];
      side_i[k] = side_q[k-1];
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      sh = {rem_i[k], num_i[k][31]};
      ge = (sh >= {1'b0, den_i[k]});
      rem_n[k] = ge ? 32'(sh - {1'b0, den_i[k]}) : sh[31:0];
      num_n[k] = {num_i[k][30:0], 1'b0};
      quo_n[k] = {quo_i[k][30:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        rem_q[k]  <= rem_n[k];
        num_q[k]  <= num_n[k];
        quo_q[k]  <= quo_n[k];
        den_q[k]  <= den_i[k];
        side_q[k] <= side_i[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_STEPS-2:0], in_valid};
    end
  end

  assign out_valid = vld[DIV_STEPS-1];
  assign quo       = quo_q[DIV_STEPS-1];
  assign side_out  = side_q[DIV_STEPS-1];

endmodule

/* rtl/core/baro_pressure_temperature_compensation.sv */
// ----------------------------------------------------------------------------
// baro_pressure_temperature_compensation
// Integer temperature and pressure compensation for a barometric sensor.
// ----------------------------------------------------------------------------
// Takes one raw sample beat (raw temperature word plus three pressure bytes)
// per clock and returns one result beat per sample, in order, through
// three prep stages, a 32-stage divider for the temperature term,
// ten stages of multiply/shift for b3, b4 and b7, a second 32-stage divider
// for the pressure quotient, four correction stages and an output register.
// Throughput is one sample per cycle; a stall on the result side freezes the
// whole pipe and holds sample.ready low. Calibration words and oversampling
// sit in an APB register file (byte address 4*i) and must only change while
// nothing is in flight. A zero divisor (x1 + md or b4) flags div_fault and
// forces both outputs to zero; otherwise temperature saturates to 16 bits
// signed and pressure to 0..1048575 Pa.
// ----------------------------------------------------------------------------
module baro_pressure_temperature_compensation import bpc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  bpc_sample_if.sink        sample,
  bpc_result_if.source      result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // ---------------- register file ----------------
  logic [31:0] cal01, cal23, cal45, cal67, cal910;
  logic [1:0]  oss;
  logic [2:0]  ridx;

  assign ridx   = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal01 <= '0; cal23 <= '0; cal45 <= '0; cal67 <= '0; cal910 <= '0;
      oss   <= OSS_RESET;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_CAL01:  cal01  <= pwdata;
        REG_CAL23:  cal23  <= pwdata;
        REG_CAL45:  cal45  <= pwdata;
        REG_CAL67:  cal67  <= pwdata;
        REG_CAL910: cal910 <= pwdata;
        REG_OSS:    oss    <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_CAL01:  prdata = cal01;
      REG_CAL23:  prdata = cal23;
      REG_CAL45:  prdata = cal45;
      REG_CAL67:  prdata = cal67;
      REG_CAL910: prdata = cal910;
      REG_OSS:    prdata = {30'd0, oss};
      default:    prdata = '0;
    endcase
  end

  // coefficient unpack
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = sx16(cal01[31:16]);
  assign ac2 = sx16(cal01[15:0]);
  assign ac3 = sx16(cal23[31:16]);
  assign ac4 = {16'd0, cal23[15:0]};
  assign ac5 = {16'd0, cal45[31:16]};
  assign ac6 = {16'd0, cal45[15:0]};
  assign b1  = sx16(cal67[31:16]);
  assign b2  = sx16(cal67[15:0]);
  assign mc  = sx16(cal910[31:16]);
  assign md  = sx16(cal910[15:0]);

  // ---------------- flow control ----------------
  // whole pipe advances unless the output register holds an untaken beat
  logic adv;
  logic o_valid;
  assign adv          = !o_valid || result.ready;
  assign sample.ready = adv;

  bpc_item_t s1, s2, s3, s4, s5, s6, s7, s8, s9, s10, s11, s12, s13;
  bpc_item_t s14, s15, s16, s17, d1_side, d2_side;
  bpc_item_t s1_next, s2_next, s3_next, s4_next, s5_next, s6_next, s7_next;
  bpc_item_t s8_next, s9_next, s10_next, s11_next, s12_next, s13_next;
  bpc_item_t s14_next, s15_next, s16_next, s17_next;
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12, v13;
  logic v14, v15, v16, v17, d1_valid, d2_valid;
  logic [31:0] d1_quo, d2_quo, d1_num, d1_den, d2_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9} <= '0;
      {v10, v11, v12, v13, v14, v15, v16, v17} <= '0;
    end else if (adv) begin
      v1 <= sample.valid; v2 <= v1; v3 <= v2;
      v4 <= d1_valid; v5 <= v4; v6 <= v5; v7 <= v6; v8 <= v7;
      v9 <= v8; v10 <= v9; v11 <= v10; v12 <= v11; v13 <= v12;
      v14 <= d2_valid; v15 <= v14; v16 <= v15; v17 <= v16;
    end
  end

  // ---------------- temperature ----------------
  always_comb begin
    // align pressure, ut - ac6 times ac5
    s1_next    = '0;
    s1_next.up = 32'({8'd0, sample.pressure_bytes} >> (4'd8 - {2'd0, oss}));
    s1_next.m0 = mulw({16'd0, sample.raw_temperature} - ac6, ac5);

    // x1 and the signed division operands
    s2_next    = s1;
    s2_next.x1 = asr(s1.m0, 15);
    s2_next.m1 = asr(s1.m0, 15) + md;
    s2_next.m2 = 32'(mc << 11);

    // sign and magnitudes for the divider
    s3_next       = s2;
    s3_next.neg   = s2.m2[31] ^ s2.m1[31];
    s3_next.fault = (s2.m1 == '0);
    s3_next.m2    = s2.m2[31] ? 32'(0 - s2.m2) : s2.m2;
    s3_next.m1    = s2.m1[31] ? 32'(0 - s2.m1) : s2.m1;
  end

  assign d1_num = s3.m2;
  assign d1_den = s3.m1;

  bpc_udiv u_div_t (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v3),
    .num(d1_num), .den(d1_den), .side_in(s3),
    .out_valid(d1_valid), .quo(d1_quo), .side_out(d1_side)
  );

  // ---------------- pressure ----------------
  always_comb begin
    logic [31:0] x2;
    x2 = d1_side.neg ? 32'(0 - d1_quo) : d1_quo;

    s4_next    = d1_side;
    s4_next.b5 = d1_side.x1 + x2;
    s4_next.tv = asr(d1_side.x1 + x2 + 32'd8, 4);

    s5_next    = s4;
    s5_next.m3 = s4.b5 - B6_OFFSET;                  // b6

    s6_next    = s5;
    s6_next.m0 = mulw(s5.m3, s5.m3);
    s6_next.m1 = mulw(ac2, s5.m3);
    s6_next.m2 = mulw(ac3, s5.m3);

    s7_next    = s6;
    s7_next.m0 = asr(s6.m0, 12);                     // sq
    s7_next.m1 = asr(s6.m1, 11);
    s7_next.m2 = asr(s6.m2, 13);

    s8_next    = s7;
    s8_next.m0 = mulw(b2, s7.m0);
    s8_next.m3 = mulw(b1, s7.m0);

    // b3 numerator and x3 of the b4 term
    s9_next    = s8;
    s9_next.m0 = 32'(((32'(ac1 << 2) + asr(s8.m0, 11) + s8.m1) << oss) + 32'd2);
    s9_next.m1 = asr(s8.m2 + asr(s8.m3, 16) + 32'd2, 2);

    // b3: divide by four toward zero
    s10_next    = s9;
    s10_next.m0 = s9.m0[31] ? asr(s9.m0 + 32'd3, 2) : asr(s9.m0, 2);
    s10_next.m1 = mulw(ac4, s9.m1 + B4_BIAS);

    s11_next    = s10;
    s11_next.b4 = s10.m1 >> 15;
    s11_next.m0 = s10.up - s10.m0;

    s12_next    = s11;
    s12_next.m0 = mulw(s11.m0, B7_SCALE >> oss);     // b7

    // b7 below 2^31: (b7*2)/b4, else (b7/b4)*2
    s13_next       = s12;
    s13_next.post  = s12.m0[31];
    s13_next.fault = s12.fault || (s12.b4 == '0);
    s13_next.m0    = s12.m0[31] ? s12.m0 : 32'(s12.m0 << 1);
  end

  assign d2_num = s13.m0;

  bpc_udiv u_div_p (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v13),
    .num(d2_num), .den(s13.b4), .side_in(s13),
    .out_valid(d2_valid), .quo(d2_quo), .side_out(d2_side)
  );

  always_comb begin
    s14_next   = d2_side;
    s14_next.p = d2_side.post ? 32'(d2_quo << 1) : d2_quo;

    s15_next    = s14;
    s15_next.m0 = mulw(asr(s14.p, 8), asr(s14.p, 8));
    s15_next.m1 = mulw(P_C2, s14.p);

    s16_next    = s15;
    s16_next.m0 = mulw(s15.m0, P_C1);

    s17_next   = s16;
    s17_next.p = s16.p + asr(asr(s16.m0, 16) + asr(s16.m1, 16) + P_C3, 4);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1  <= s1_next;  s2  <= s2_next;  s3  <= s3_next;  s4  <= s4_next;
      s5  <= s5_next;  s6  <= s6_next;  s7  <= s7_next;  s8  <= s8_next;
      s9  <= s9_next;  s10 <= s10_next; s11 <= s11_next; s12 <= s12_next;
      s13 <= s13_next; s14 <= s14_next; s15 <= s15_next; s16 <= s16_next;
      s17 <= s17_next;
    end
  end

  // ---------------- output register: saturate, fault ----------------
  logic signed [15:0] o_temp;
  logic [19:0]        o_pres;
  logic               o_fault;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= v17;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_fault <= s17.fault;
      if (s17.fault) begin
        o_temp <= '0;
        o_pres <= '0;
      end else begin
        if ($signed(s17.tv) > 32'sd32767) begin
          o_temp <= 16'sh7FFF;
        end else if ($signed(s17.tv) < -32'sd32768) begin
          o_temp <= 16'sh8000;
        end else begin
          o_temp <= s17.tv[15:0];
        end
        if (s17.p[31]) begin
          o_pres <= '0;
        end else if (s17.p > PRES_MAX) begin
          o_pres <= PRES_MAX[19:0];
        end else begin
          o_pres <= s17.p[19:0];
        end
      end
    end
  end

  assign result.valid       = o_valid;
  assign result.temperature = o_temp;
  assign result.pressure    = o_pres;
  assign result.div_fault   = o_fault;

endmodule

/* rtl/core/bpc_checker.sv */
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks for the compensation core, bound to the top level.
// ----------------------------------------------------------------------------
module bpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] temperature,
  input logic [19:0] pressure,
  input logic        div_fault,
  input logic        pready
);

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(temperature) &&
    $stable(pressure) && $stable(div_fault))
    else $error("result beat changed under stall");

  // input side ready only when the output register can move
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("sample ready inconsistent with result stall");

  a_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_fault |-> temperature == '0 && pressure == '0)
    else $error("fault beat with nonzero outputs");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready dropped");

endmodule

bind baro_pressure_temperature_compensation bpc_checker u_bpc_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(sample.ready),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .temperature(result.temperature),
  .pressure(result.pressure),
  .div_fault(result.div_fault),
  .pready(pready)
);
